// ===== sv/rgb_blur_sharpen_3x3_filter_unit_assert.svh =====
// assertion macros shared by the filter unit's checkers
// no dependencies; clk and rst_n must be visible where a macro is used
`ifndef RGB_BLUR_SHARPEN_3X3_FILTER_UNIT_ASSERT_SVH
`define RGB_BLUR_SHARPEN_3X3_FILTER_UNIT_ASSERT_SVH

// property checked outside reset
`define RBSF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RBSF_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rbsf_pkg.sv =====
// shared types and constants of the rgb 3x3 blur/sharpen filter unit
// no dependencies
package rbsf_pkg;

  // one rgb pixel, red in the top byte
  typedef logic [23:0] rbsf_pix_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_MAX_VALUE    = 2'd3
  } rbsf_cfg_idx_t;

  // filter modes
  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  // register widths and reset values
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 12;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [7:0]  MAXV_RESET   = 8'd255;

  // geometry limits
  localparam logic [12:0] DIM_MIN      = 13'd3;
  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

  // divide by 9 as multiply by reciprocal, exact for sums up to 9*255
  localparam logic [12:0] DIV9_RECIP = 13'd7282;

  // window results handed from the window stage to the output stage
  typedef struct packed {
    logic [2:0][11:0] blur_sum;   // 3x3 box sum per channel
    logic [2:0][11:0] sharp;      // signed 5*centre minus edge neighbours
    logic             frame_last;
  } rbsf_calc_t;

endpackage

// ===== sv/rbsf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module rbsf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, output holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rbsf_window.sv =====
// 3x3 window columns and the per-channel box sum and sharpen terms
// depends on rbsf_pkg
module rbsf_window (
  input  logic               clk,
  input  logic               shift,
  input  rbsf_pkg::rbsf_pix_t fresh_top,
  input  rbsf_pkg::rbsf_pix_t fresh_mid,
  input  rbsf_pkg::rbsf_pix_t fresh_bot,
  input  logic               frame_last,
  output rbsf_pkg::rbsf_calc_t calc
);
  import rbsf_pkg::*;

  // [0] top, [1] middle, [2] bottom
  rbsf_pix_t cc_r [3];   // newest stored column
  rbsf_pix_t lc_r [3];   // older stored column

  // column shift as each pixel retires
  always_ff @(posedge clk) begin
    if (shift) begin
      lc_r[0] <= cc_r[0];
      lc_r[1] <= cc_r[1];
      lc_r[2] <= cc_r[2];
      cc_r[0] <= fresh_top;
      cc_r[1] <= fresh_mid;
      cc_r[2] <= fresh_bot;
    end
  end

  // per channel: box sum and 5*centre - up - down - left - right
  always_comb begin
    logic [11:0] ctr;
    calc.frame_last = frame_last;
    for (int c = 0; c < 3; c++) begin
      calc.blur_sum[c] = 12'(lc_r[0][c*8 +: 8]) + 12'(lc_r[1][c*8 +: 8])
                       + 12'(lc_r[2][c*8 +: 8]) + 12'(cc_r[0][c*8 +: 8])
                       + 12'(cc_r[1][c*8 +: 8]) + 12'(cc_r[2][c*8 +: 8])
                       + 12'(fresh_top[c*8 +: 8]) + 12'(fresh_mid[c*8 +: 8])
                       + 12'(fresh_bot[c*8 +: 8]);
      ctr = 12'(cc_r[1][c*8 +: 8]);
      calc.sharp[c] = (ctr << 2) + ctr
                    - 12'(cc_r[0][c*8 +: 8]) - 12'(cc_r[2][c*8 +: 8])
                    - 12'(lc_r[1][c*8 +: 8]) - 12'(fresh_mid[c*8 +: 8]);
    end
  end

endmodule

// ===== sv/rbsf_post.sv =====
// result stage: window result register, divide by 9 or saturate, then the output register
// depends on rbsf_pkg
module rbsf_post (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rbsf_pkg::rbsf_calc_t calc,
  input  logic                 filter_mode,
  input  logic [7:0]           max_value,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_frame_last
);
  import rbsf_pkg::*;

  logic       s2_v_r;
  rbsf_calc_t s2_r;
  logic       out_v_r;
  logic [2:0][7:0] res_r;
  logic       last_r;
  logic [2:0][7:0] res_nxt;
  logic       out_en;
  logic       s2_en;

  assign out_en = !out_v_r || !out_stall;
  assign s2_en  = !s2_v_r || out_en;
  assign ready  = s2_en;

  // mode-dependent channel result
  always_comb begin
    logic [24:0] prod;
    logic [11:0] sv;
    for (int c = 0; c < 3; c++) begin
      prod = 25'(s2_r.blur_sum[c]) * 25'(DIV9_RECIP);
      sv   = s2_r.sharp[c];
      if (filter_mode == MODE_BLUR) begin
        res_nxt[c] = prod[23:16];
      end else if (sv[11]) begin
        res_nxt[c] = 8'd0;
      end else if (sv > 12'(max_value)) begin
        res_nxt[c] = max_value;
      end else begin
        res_nxt[c] = sv[7:0];
      end
    end
  end

  // window result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= push;
    end
    if (s2_en && push) begin
      s2_r <= calc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s2_v_r;
    end
    if (out_en && s2_v_r) begin
      res_r  <= res_nxt;
      last_r <= s2_r.frame_last;
    end
  end

  assign out_valid      = out_v_r;
  assign out_red        = res_r[2];
  assign out_green      = res_r[1];
  assign out_blue       = res_r[0];
  assign out_frame_last = last_r;

endmodule

// ===== sv/rgb_blur_sharpen_3x3_filter_unit.sv =====
// top level of the rgb 3x3 blur/sharpen filter unit
// depends on rbsf_pkg, rbsf_ram, rbsf_window, rbsf_post
//
// Takes one raster-order rgb pixel per clock and gives one filtered pixel for
// each interior position (row and column both past the first two), on the
// pixel that completes its 3x3 window; border positions give nothing. The
// unstalled rate is one pixel per cycle, set by the single line-store ram,
// which holds both previous rows of a column in one 48-bit entry and is read
// once and written once per pixel. A result passes the read stage, window
// result and output registers. in_stall rises only when the output register
// and the stage before it both hold results, out_stall is high and the pixel
// in flight has one to deliver. The line store needs no clearing after reset.
// Configuration (mode, width, height, max value) is taken by cfg_valid with
// cfg_ready always high, and is meant to change only between frames.
module rgb_blur_sharpen_3x3_filter_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [rbsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbsf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);

  // configuration registers
  logic        mode_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [7:0]  maxv_r;

  // position counters
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  // pixel waiting on its line-store read
  logic          s1_v_r;
  rbsf_pix_t     s1_px_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_int_r;
  logic          s1_last_r;

  logic [12:0] w_eff, h_eff, w_last, h_last;
  logic        col_end, row_end, interior;
  logic        accept, s1_move, post_ready;
  logic [47:0] ram_rdata;
  rbsf_calc_t  calc;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BLUR;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      maxv_r   <= MAXV_RESET;
    end else if (cfg_valid) begin
      unique case (rbsf_cfg_idx_t'(cfg_index))
        CFG_FILTER_MODE:  mode_r   <= cfg_data[0];
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[12:0];
        CFG_MAX_VALUE:    maxv_r   <= cfg_data[7:0];
      endcase
    end
  end

  // geometry saturated to the supported range
  always_comb begin
    if (13'(width_r) < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (13'(width_r) > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = 13'(width_r);
    end
    if (height_r < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (height_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = height_r;
    end
  end

  assign w_last   = w_eff - 13'd1;
  assign h_last   = h_eff - 13'd1;
  assign col_end  = 13'(col_r) >= w_last;
  assign row_end  = 13'(row_r) >= h_last;
  assign interior = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));

  // handshake: a pixel without a result retires regardless of the output side
  assign s1_move  = s1_v_r && (!s1_int_r || post_ready);
  assign in_stall = s1_v_r && !s1_move;
  assign accept   = in_valid && !in_stall;

  // raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
    if (accept) begin
      s1_px_r   <= {in_red, in_green, in_blue};
      s1_col_r  <= col_r;
      s1_int_r  <= interior;
      s1_last_r <= col_end && row_end;
    end
  end

  // line store: entry holds {row two up, row one up} of a column
  rbsf_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata ({ram_rdata[23:0], s1_px_r}),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  rbsf_window u_window (
    .clk        (clk),
    .shift      (s1_move),
    .fresh_top  (ram_rdata[47:24]),
    .fresh_mid  (ram_rdata[23:0]),
    .fresh_bot  (s1_px_r),
    .frame_last (s1_last_r),
    .calc       (calc)
  );

  rbsf_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (s1_move && s1_int_r),
    .calc           (calc),
    .filter_mode    (mode_r),
    .max_value      (maxv_r),
    .ready          (post_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== sv/rbsf_checker.sv =====
// port-level checks of the filter unit, bound to the top level
// depends on rgb_blur_sharpen_3x3_filter_unit_assert.svh
`include "rgb_blur_sharpen_3x3_filter_unit_assert.svh"

module rbsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_frame_last
);

  // nothing is left in the output register by reset
  `RBSF_CHECK_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")

  // input backs up only when the output side is full and stalled
  `RBSF_CHECK(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "spurious in_stall")

  // a stalled result stays offered
  `RBSF_CHECK(a_out_hold, out_valid && out_stall |=> out_valid, "out_valid dropped")

  // a stalled result does not change
  `RBSF_CHECK(a_out_stable, out_valid && out_stall |=> $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_frame_last), "stalled beat changed")

endmodule

bind rgb_blur_sharpen_3x3_filter_unit rbsf_checker u_rbsf_checker (.*);

// ===== test/rgb_blur_sharpen_3x3_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for rgb_blur_sharpen_3x3_filter_unit: streams frames, compares beats
// depends on rbsf_pkg and the filter unit rtl; holds its own blur/sharpen predictor
module rgb_blur_sharpen_3x3_filter_unit_tb;
  import rbsf_pkg::*;

  localparam int LINE_DEPTH     = 1024;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {PAT_RANDOM, PAT_EXTREME} pix_pattern_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } filtered_px_t;

  // predicts filtered pixels from accepted input pixels and checks output beats
  class blur_sharpen_predictor;
    rbsf_pix_t    row_above2 [LINE_DEPTH];
    rbsf_pix_t    row_above1 [LINE_DEPTH];
    logic [7:0]   win_cols [2][9];
    int unsigned  col_cnt;
    int unsigned  row_cnt;
    logic         mode;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    logic [7:0]   maxv_reg;
    filtered_px_t filtered_q [$];
    int           errors;
    int unsigned  taken;

    function new();
      foreach (row_above2[i]) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      foreach (win_cols[k, p]) win_cols[k][p] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mode       = MODE_BLUR;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      maxv_reg   = MAXV_RESET;
      errors     = 0;
      taken      = 0;
    endfunction

    function void set_reg(rbsf_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FILTER_MODE:  mode       = data[0];
        CFG_IMAGE_WIDTH:  width_reg  = data[10:0];
        CFG_IMAGE_HEIGHT: height_reg = data[12:0];
        CFG_MAX_VALUE:    maxv_reg   = data[7:0];
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    function int unsigned pixels_taken_total();
      return taken;
    endfunction

    function void take_pixel(rbsf_pix_t px);
      int unsigned  w;
      int unsigned  h;
      int unsigned  c;
      logic [7:0]   fresh [9];
      logic [7:0]   chan_res [3];
      bit           col_end;
      bit           row_end;
      int           acc;
      filtered_px_t f;
      // effective geometry, clamped to what the line store and row counter allow
      w = width_reg;
      if (w < 3) w = 3;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > int'(HEIGHT_LIMIT)) h = HEIGHT_LIMIT;
      col_end = col_cnt >= w - 1;
      row_end = row_cnt >= h - 1;
      c = (col_cnt >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_cnt;
      // new column of the window: two rows above from the line stores, then this pixel
      for (int ch = 0; ch < 3; ch++) begin
        fresh[ch]     = row_above2[c][23-8*ch -: 8];
        fresh[3 + ch] = row_above1[c][23-8*ch -: 8];
        fresh[6 + ch] = px[23-8*ch -: 8];
      end
      // full window: result for the centre pixel
      if (row_cnt >= 2 && col_cnt >= 2) begin
        for (int ch = 0; ch < 3; ch++) begin
          if (mode == MODE_BLUR) begin
            acc = 0;
            for (int p = 0; p < 3; p++)
              acc += int'(win_cols[1][3*p + ch]) + int'(win_cols[0][3*p + ch])
                     + int'(fresh[3*p + ch]);
            acc = acc / 9;
          end else begin
            acc = 5 * int'(win_cols[0][3 + ch]) - int'(win_cols[0][ch])
                  - int'(win_cols[0][6 + ch]) - int'(win_cols[1][3 + ch])
                  - int'(fresh[3 + ch]);
            if (acc < 0) acc = 0;
            if (acc > int'(maxv_reg)) acc = int'(maxv_reg);
          end
          chan_res[ch] = acc[7:0];
        end
        f.red   = chan_res[0];
        f.green = chan_res[1];
        f.blue  = chan_res[2];
        f.last  = col_end && row_end;
        filtered_q.push_back(f);
      end
      // shift window and line stores
      win_cols[1]   = win_cols[0];
      win_cols[0]   = fresh;
      row_above2[c] = row_above1[c];
      row_above1[c] = px;
      // raster position
      if (col_end) begin
        col_cnt = 0;
        row_cnt = row_end ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col_cnt + 1;
      end
      taken++;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_filtered(filtered_px_t got);
      filtered_px_t want;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: expected none, actual r=%0d g=%0d b=%0d last=%0b",
                 $time, got.red, got.green, got.blue, got.last);
        return;
      end
      want = filtered_q.pop_front();
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_frame_last", want.last, got.last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  out_frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blur_sharpen_predictor sb;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;

  rgb_blur_sharpen_3x3_filter_unit #(
    .MAX_WIDTH(LINE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // output beat check and watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_filtered({out_red, out_green, out_blue, out_frame_last});
    if ((in_valid && !in_stall) || (rst_n && out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL rgb_blur_sharpen_3x3_filter_unit");
        $finish;
      end
    end
  end

  function automatic rbsf_pix_t make_pixel(pix_pattern_t pat);
    rbsf_pix_t px;
    px = rbsf_pix_t'($urandom);
    if (pat == PAT_EXTREME)
      for (int ch = 0; ch < 3; ch++) px[8*ch +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    return px;
  endfunction

  // one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input rbsf_pix_t px);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px[23:16];
    in_green <= px[15:8];
    in_blue  <= px[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_pixel(px);
  endtask

  task automatic program_reg(input rbsf_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every expected pixel is out and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup(input logic mode, input logic [CFG_DATA_W-1:0] width,
                       input logic [CFG_DATA_W-1:0] height, input logic [7:0] maxv);
    settle();
    program_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
    program_reg(CFG_IMAGE_WIDTH, width);
    program_reg(CFG_IMAGE_HEIGHT, height);
    program_reg(CFG_MAX_VALUE, CFG_DATA_W'(maxv));
  endtask

  // pixels until the raster position wraps back to the frame start
  task automatic send_frame(input pix_pattern_t pat);
    do send_pixel(make_pixel(pat)); while (!sb.at_frame_start());
  endtask

  task automatic random_frames(input int quota);
    int          start;
    logic [7:0]  maxv;
    start = sb.pixels_taken_total();
    while (sb.pixels_taken_total() - start < quota) begin
      case ($urandom_range(3))
        0:       maxv = 8'd255;
        1:       maxv = 8'($urandom_range(255, 1));
        2:       maxv = 8'($urandom_range(40));
        default: maxv = 8'($urandom_range(255));
      endcase
      setup(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(13)),
            CFG_DATA_W'($urandom_range(9)), maxv);
      send_frame($urandom_range(3) == 0 ? PAT_EXTREME : PAT_RANDOM);
    end
  endtask

  // shrink or keep the geometry partway through a frame, then run the frame out
  task automatic reshape_mid_frame();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = $urandom_range(12, 6);
    h = $urandom_range(8, 5);
    setup(1'($urandom_range(1)), CFG_DATA_W'(w), CFG_DATA_W'(h), 8'd255);
    n = $urandom_range((h - 1) * w - 1, 2 * w + 3);
    repeat (n) send_pixel(make_pixel(PAT_RANDOM));
    settle();
    program_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(w, 3)));
    program_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(h, 3)));
    while (!sb.at_frame_start()) send_pixel(make_pixel(PAT_RANDOM));
  endtask

  initial begin
    sb             = new();
    quiet_cycles   = 0;
    src_idle_pct   = 12;
    sink_stall_pct = 86;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_FILTER_MODE;
    cfg_data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset mode and max value, geometry below range clamps to 3x3, all-white frame
    program_reg(CFG_IMAGE_WIDTH, 0);
    program_reg(CFG_IMAGE_HEIGHT, 1);
    repeat (9) send_pixel(24'hFFFFFF);
    // sharpen with zero max value
    setup(MODE_SHARPEN, 3, 3, 8'd0);
    send_frame(PAT_EXTREME);
    // sharpen, bright centre on black saturates at max value
    setup(MODE_SHARPEN, 3, 3, 8'd200);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 24'hFFFFFF : 24'h000000);

    random_frames(80);

    settle();
    src_idle_pct   = 86;
    sink_stall_pct = 12;
    random_frames(80);

    settle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (4) reshape_mid_frame();
    // widest rows: width above range clamps to the line store depth, so the first
    // row wraps after LINE_DEPTH pixels; a narrow width then runs the frame out
    setup(MODE_SHARPEN, 13'h1FFF, 3, 8'd255);
    repeat (LINE_DEPTH + 4) send_pixel(make_pixel(PAT_RANDOM));
    settle();
    program_reg(CFG_IMAGE_WIDTH, 4);
    while (!sb.at_frame_start()) send_pixel(make_pixel(PAT_RANDOM));
    random_frames(80);

    settle();
    if (sb.errors == 0) begin
      $display("PASS rgb_blur_sharpen_3x3_filter_unit");
    end else begin
      $display("FAIL rgb_blur_sharpen_3x3_filter_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rbsf_pkg.sv
sv/rbsf_ram.sv
sv/rbsf_window.sv
sv/rbsf_post.sv
sv/rgb_blur_sharpen_3x3_filter_unit.sv
sv/rbsf_checker.sv
test/rgb_blur_sharpen_3x3_filter_unit_tb.sv
